// File: rtl/pdf_pkg.sv
`timescale 1ns / 1ps

package pdf_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_START,
        S_RESULT
    } t_state;

    // Sender table search status
    typedef struct packed {
        logic hit;   // a valid slot holds the address
        logic full;  // every slot is valid
    } t_lookup;

    // Control strobes of the sequencer
    typedef struct packed {
        logic in_ready;
        logic ram_rd;
        logic ram_wr;
        logic tbl_wr;
        logic out_load;
    } t_ctrl;

endpackage

// File: rtl/pdf_sender_table.sv
`timescale 1ns / 1ps

module pdf_sender_table
    import pdf_pkg::*;
#(
    parameter int SENDER_SLOTS = 4,
    parameter int SW           = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_addr,
    output t_lookup       o_flags,
    output logic [SW-1:0] o_hit_slot,
    output logic [SW-1:0] o_free_slot,
    input  logic          i_wr_en,
    input  logic [SW-1:0] i_wr_slot,
    input  logic [31:0]   i_wr_addr
);

    logic [SENDER_SLOTS-1:0] r_valid;
    logic [31:0]             r_addr [SENDER_SLOTS];

    // Valid bits: cleared by reset, set when a slot is started
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_slot] <= 1'b1;
        end
    end

    // Sender addresses, payload only
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_addr[i_wr_slot] <= i_wr_addr;
        end
    end

    // Parallel compare, lowest index wins; lowest free slot, or 0 when full
    always_comb begin
        o_flags.hit  = 1'b0;
        o_flags.full = &r_valid;
        o_hit_slot   = '0;
        o_free_slot  = '0;
        for (int s = SENDER_SLOTS - 1; s >= 0; s--) begin
            if (r_valid[s] && (r_addr[s] == i_addr)) begin
                o_flags.hit = 1'b1;
                o_hit_slot  = SW'(s);
            end
            if (!r_valid[s]) begin
                o_free_slot = SW'(s);
            end
        end
    end

endmodule

// File: rtl/per_sender_duplicate_filter.sv
`timescale 1ns / 1ps
// Per-sender duplicate filter.
// Slave stream: one beat per event, tdata = {event_id, source_address}.
// Master stream: one beat per event, tdata = {recycled, slot_used, is_new}.
// A sender table of SENDER_SLOTS slots (valid bit + address, in flops) is
// searched in parallel; each slot owns a ring of WINDOW_DEPTH recent event
// ids held in one synchronous single-port-read memory.
// An unknown sender starts a slot holding the new id; for a known sender
// the fill ids held for that sender (at most WINDOW_DEPTH) are scanned
// until one repeats the incoming id or all are read, and a new id is then
// written at the head. The ring memory delivers one stored id per cycle.
// One event is worked at a time; o_s_axis_tready is high only between
// events, but a finished result sitting in the output register does not
// hold off the next event. An event that finishes while the output register
// still holds an untaken beat waits until i_m_axis_tready frees it.
// Reset (i_rst_n low, synchronous) empties the table and all fill counts and
// heads at once; ring contents need no clearing since only filled entries
// are read. The block accepts events in the first cycle after reset.
module per_sender_duplicate_filter
    import pdf_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8,
    parameter int SENDER_SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // [31:0] source_address, [63:32] event_id
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata   // [0] is_new, [2:1] slot_used, [3] recycled
);

    localparam int SW        = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
    localparam int PW        = $clog2(WINDOW_DEPTH);
    localparam int FW        = $clog2(WINDOW_DEPTH + 1);
    localparam int AW        = SW + PW;
    localparam int RAM_DEPTH = SENDER_SLOTS << PW;

    t_state  r_state, n_state;
    t_ctrl   ctrl;
    t_lookup lk;

    logic [31:0]   r_src, r_id;
    logic [SW-1:0] r_slot;
    logic          r_recycled;
    logic [FW-1:0] r_fill_cur;
    logic [PW-1:0] r_head_cur;
    logic [FW-1:0] r_idx;
    logic          r_rd_pend;
    logic          r_is_new;
    logic          n_is_new;

    logic [FW-1:0] r_fill [SENDER_SLOTS];
    logic [PW-1:0] r_head [SENDER_SLOTS];

    logic [31:0]   ring [RAM_DEPTH];
    logic [31:0]   r_ram_q;
    logic [AW-1:0] ram_addr;

    logic [SW-1:0] hit_slot, free_slot;
    logic          scan_match, scan_done;

    logic          r_ovalid;
    logic [7:0]    r_odata;
    logic [SW+1:0] slot_ext;
    logic          accept;

    pdf_sender_table #(
        .SENDER_SLOTS(SENDER_SLOTS),
        .SW          (SW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_addr     (r_src),
        .o_flags    (lk),
        .o_hit_slot (hit_slot),
        .o_free_slot(free_slot),
        .i_wr_en    (ctrl.tbl_wr),
        .i_wr_slot  (r_slot),
        .i_wr_addr  (r_src)
    );

    assign accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign scan_match = r_rd_pend && (r_ram_q == r_id);
    assign scan_done  = (r_idx == r_fill_cur);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                n_state = lk.hit ? S_SCAN : S_START;
            end
            S_SCAN: begin
                if (scan_match || scan_done) n_state = S_RESULT;
            end
            S_START: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_ovalid || i_m_axis_tready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control strobes
    always_comb begin
        ctrl     = '0;
        n_is_new = r_is_new;
        case (r_state)
            S_IDLE: begin
                ctrl.in_ready = 1'b1;
            end
            S_SCAN: begin
                if (scan_match) begin
                    n_is_new = 1'b0;
                end else if (scan_done) begin
                    ctrl.ram_wr = 1'b1;
                    n_is_new    = 1'b1;
                end else begin
                    ctrl.ram_rd = 1'b1;
                end
            end
            S_START: begin
                ctrl.ram_wr = 1'b1;
                ctrl.tbl_wr = 1'b1;
                n_is_new    = 1'b1;
            end
            S_RESULT: begin
                ctrl.out_load = !r_ovalid || i_m_axis_tready;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    // No beat is taken while reset is held
    assign o_s_axis_tready = ctrl.in_ready && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Event capture and lookup result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src <= i_s_axis_tdata[31:0];
            r_id  <= i_s_axis_tdata[63:32];
        end
        if (r_state == S_LOOKUP) begin
            r_slot     <= lk.hit ? hit_slot : free_slot;
            r_recycled <= !lk.hit && lk.full;
            r_fill_cur <= r_fill[lk.hit ? hit_slot : free_slot];
            r_head_cur <= r_head[lk.hit ? hit_slot : free_slot];
        end
        r_is_new <= n_is_new;
    end

    // Scan counter and read-pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= ctrl.ram_rd;
            if (r_state == S_LOOKUP) begin
                r_idx <= '0;
            end else if (ctrl.ram_rd) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Per-slot fill count and head pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SENDER_SLOTS; s++) begin
                r_fill[s] <= '0;
                r_head[s] <= '0;
            end
        end else if (r_state == S_START) begin
            r_fill[r_slot] <= FW'(1);
            r_head[r_slot] <= PW'(1);
        end else if (ctrl.ram_wr) begin
            if (r_fill_cur < FW'(WINDOW_DEPTH)) begin
                r_fill[r_slot] <= r_fill_cur + 1'b1;
            end
            r_head[r_slot] <= (r_head_cur == PW'(WINDOW_DEPTH - 1)) ? '0
                                                                     : r_head_cur + 1'b1;
        end
    end

    // Ring memory: one read or one write per cycle, registered read data
    always_comb begin
        if (r_state == S_START) begin
            ram_addr = {r_slot, {PW{1'b0}}};
        end else if (ctrl.ram_wr) begin
            ram_addr = {r_slot, r_head_cur};
        end else begin
            ram_addr = {r_slot, r_idx[PW-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.ram_wr) begin
            ring[ram_addr] <= r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.ram_rd) begin
            r_ram_q <= ring[ram_addr];
        end
    end

    // Output register
    assign slot_ext = {2'b00, r_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_odata <= {4'b0000, r_recycled, slot_ext[1:0], r_is_new};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // Checks
    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOOKUP))
        else $error("accepted beat did not start a lookup");

    a_ram_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl.ram_wr && ctrl.ram_rd))
        else $error("ring memory read and write in one cycle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_fill_cur <= FW'(WINDOW_DEPTH) && r_fill_cur != '0))
        else $error("known sender with fill out of range");

    a_recycle_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.out_load && r_recycled) |-> (r_slot == '0 && r_is_new))
        else $error("recycled result not on slot 0");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |=> o_m_axis_tvalid)
        else $error("result beat lost");

endmodule
